### src/dwc_pkg.sv
// Package for the depthwise 3x3 convolution block: shared widths, register
// indexes, reset values and the push record between the datapath and the output queue.
// No dependencies.
`timescale 1ns / 1ps

package dwc_pkg;

  // Fixed field widths.
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int OUT_W      = 12;
  localparam int POS_W      = 10;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int SHAPE_W    = 23;
  localparam int NCH        = 3;
  localparam int NPACKS     = 7;
  localparam int TAPS       = 9;
  localparam int PROD_W     = 32;
  localparam int ROWSUM_W   = 34;
  localparam int ACC_W      = 36;
  localparam int FRAC_SHIFT = 12;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SHAPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST  = 3'd1;

  // Reset of the frame shape register: 1024 x 1024, identity off.
  localparam logic [SHAPE_W-1:0] FRAME_SHAPE_RESET = 23'd2098176;

  // Frame height limit and the clamp ceiling (1.0 in Q.11).
  localparam int MAX_FRAME_HEIGHT = 1024;
  localparam logic [OUT_W-1:0] CLAMP_MAX = 12'd2048;

  // Record that travels with an item from the window stage to the output queue.
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } push_t;

endpackage

### src/dwc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dwc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/dwc_lane.sv
// One channel lane: nine multiplies, a two-level adder tree and the clamp to [0, 1].
// Depends on dwc_pkg.
`timescale 1ns / 1ps

module dwc_lane (
  input  logic                              clk,
  input  logic signed [dwc_pkg::SAMPLE_W-1:0] taps [dwc_pkg::TAPS],
  input  logic signed [dwc_pkg::COEF_W-1:0]   coefs [dwc_pkg::TAPS],
  input  logic                              ident,
  input  logic signed [dwc_pkg::SAMPLE_W-1:0] center,
  output logic [dwc_pkg::OUT_W-1:0]           result
);

  logic signed [dwc_pkg::PROD_W-1:0]   prod [dwc_pkg::TAPS];
  logic signed [dwc_pkg::ROWSUM_W-1:0] rowsum [3];
  logic signed [dwc_pkg::ACC_W-1:0]    total;
  logic signed [dwc_pkg::ACC_W-1:0]    shifted;
  logic [dwc_pkg::OUT_W-1:0]           ident_val;
  logic [dwc_pkg::OUT_W-1:0]           ident_a;
  logic [dwc_pkg::OUT_W-1:0]           ident_b;
  logic                                ident_a_sel;
  logic                                ident_b_sel;

  // Pass-through value for identity mode, clamped to [0, 2048].
  always_comb begin
    if (center < 0) begin
      ident_val = '0;
    end else if (center > $signed({4'b0, dwc_pkg::CLAMP_MAX})) begin
      ident_val = dwc_pkg::CLAMP_MAX;
    end else begin
      ident_val = dwc_pkg::OUT_W'(center);
    end
  end

  // Stage A: products.
  always_ff @(posedge clk) begin
    for (int i = 0; i < dwc_pkg::TAPS; i++) begin
      prod[i] <= dwc_pkg::PROD_W'(taps[i] * coefs[i]);
    end
    ident_a     <= ident_val;
    ident_a_sel <= ident;
  end

  // Stage B: one sum per kernel row.
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      rowsum[r] <= dwc_pkg::ROWSUM_W'(prod[3*r]) + dwc_pkg::ROWSUM_W'(prod[3*r+1])
                 + dwc_pkg::ROWSUM_W'(prod[3*r+2]);
    end
    ident_b     <= ident_a;
    ident_b_sel <= ident_a_sel;
  end

  // Stage C: total, truncation to Q.11 and clamp.
  always_comb begin
    total   = dwc_pkg::ACC_W'(rowsum[0]) + dwc_pkg::ACC_W'(rowsum[1])
            + dwc_pkg::ACC_W'(rowsum[2]);
    shifted = total >>> dwc_pkg::FRAC_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (ident_b_sel) begin
      result <= ident_b;
    end else if (total < 0) begin
      result <= '0;
    end else if (shifted > $signed({24'b0, dwc_pkg::CLAMP_MAX})) begin
      result <= dwc_pkg::CLAMP_MAX;
    end else begin
      result <= dwc_pkg::OUT_W'(shifted);
    end
  end

endmodule

### src/dwc_merge.sv
// Output stage: merges the lane results with position and frame-end flag into
// one word and queues it for the output channel. Depends on dwc_pkg.
`timescale 1ns / 1ps

module dwc_merge #(
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  dwc_pkg::push_t                           push,
  input  logic [dwc_pkg::NCH-1:0][dwc_pkg::OUT_W-1:0] lane_res,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [dwc_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  output logic                                     m_axis_tlast
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [dwc_pkg::OUT_TDATA_W-1:0] data_q [DEPTH];
  logic                            last_q [DEPTH];
  logic [PW-1:0]                   wr_ptr;
  logic [PW-1:0]                   rd_ptr;
  logic [CW-1:0]                   count;
  logic                            pop;
  logic [dwc_pkg::OUT_TDATA_W-1:0] word;

  // Word layout from bit 0: row, col, ch0, ch1, ch2.
  assign word = {lane_res[2], lane_res[1], lane_res[0], push.col, push.row};
  assign pop  = m_axis_tvalid && m_axis_tready;

  // Queue storage; the upstream credit count keeps pushes off a full queue.
  always_ff @(posedge clk) begin
    if (push.valid) begin
      data_q[wr_ptr] <= word;
      last_q[wr_ptr] <= push.last;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push.valid) - CW'(pop);
    end
  end

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = data_q[rd_ptr];
  assign m_axis_tlast  = last_q[rd_ptr];

endmodule

### src/depthwise_conv3x3_clamp.sv
// Top level of the depthwise 3x3 convolution with clamp: counters, line stores,
// sliding window, channel lanes and the output queue. Depends on dwc_pkg,
// dwc_ram, dwc_lane and dwc_merge.
`timescale 1ns / 1ps

// Usage:
// Pixels enter on the s_axis channel in raster order, one word per pixel with
// the three channel samples. Results leave on the m_axis channel, one word per
// interior pixel with its row, column and three clamped channel values; tlast
// marks the last result of a frame. Border pixels are consumed without output.
// The user must write the frame shape (index 0) and the seven coefficient
// packs (indexes 1 to 7) on the configuration port only while the block is
// idle; the block itself does not enforce this. Throughput is one pixel per
// cycle while s_axis_tready is high. A result reaches m_axis through the
// line store read and window registers loaded at the accepting edge, the
// three lane stages (multiply, row sums, total and clamp) and the queue write.
// An eight-word output queue decouples the receiver. When the receiver stalls,
// s_axis_tready falls once eight results are pending between the input and
// the port, so no word is ever dropped. Reset clears the counters, the window,
// the queue and the registers; the line stores are not cleared and need no
// clearing pass, since every entry is written before a result depends on it.

module depthwise_conv3x3_clamp #(
  parameter int MAX_LINE_WIDTH = 1024,
  parameter int NUM_CHANNELS   = 3,
  parameter int SAMPLE_BITS    = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // Fields from bit 0: sample_ch0, sample_ch1, sample_ch2.
  input  logic [dwc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: result_row, result_col, out_ch0, out_ch1, out_ch2.
  output logic [dwc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic                               m_axis_tlast,
  input  logic                               cfg_we,
  input  logic [dwc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dwc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW         = (MAX_LINE_WIDTH > 1) ? $clog2(MAX_LINE_WIDTH) : 1;
  localparam int SW         = dwc_pkg::SAMPLE_W;
  localparam int SB         = (SAMPLE_BITS < SW) ? SAMPLE_BITS : SW;
  localparam int LW         = NUM_CHANNELS * SW;
  localparam int FIFO_DEPTH = 8;
  localparam int RW         = $clog2(FIFO_DEPTH + 1);
  localparam int XW         = 13;

  // Configuration registers.
  logic [dwc_pkg::SHAPE_W-1:0]    frame_shape;
  logic [dwc_pkg::CFG_DATA_W-1:0] coef_pack [dwc_pkg::NPACKS];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_shape <= dwc_pkg::FRAME_SHAPE_RESET;
      for (int p = 0; p < dwc_pkg::NPACKS; p++) begin
        coef_pack[p] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == dwc_pkg::REG_FRAME_SHAPE) begin
        frame_shape <= cfg_data[dwc_pkg::SHAPE_W-1:0];
      end else begin
        coef_pack[cfg_index - dwc_pkg::REG_COEF_FIRST] <= cfg_data;
      end
    end
  end

  // Frame dimensions saturated into their legal ranges.
  logic [XW-1:0] width_raw;
  logic [XW-1:0] height_raw;
  logic [XW-1:0] width_sat;
  logic [XW-1:0] height_sat;
  logic          identity;

  always_comb begin
    width_raw  = XW'(frame_shape[dwc_pkg::DIM_W-1:0]);
    height_raw = XW'(frame_shape[2*dwc_pkg::DIM_W-1:dwc_pkg::DIM_W]);
    identity   = frame_shape[2*dwc_pkg::DIM_W];
    if (width_raw < XW'(3)) begin
      width_sat = XW'(3);
    end else if (width_raw > XW'(MAX_LINE_WIDTH)) begin
      width_sat = XW'(MAX_LINE_WIDTH);
    end else begin
      width_sat = width_raw;
    end
    if (height_raw < XW'(3)) begin
      height_sat = XW'(3);
    end else if (height_raw > XW'(dwc_pkg::MAX_FRAME_HEIGHT)) begin
      height_sat = XW'(dwc_pkg::MAX_FRAME_HEIGHT);
    end else begin
      height_sat = height_raw;
    end
  end

  // Input handshake and position decode.
  logic [dwc_pkg::DIM_W-1:0] column_count;
  logic [dwc_pkg::DIM_W-1:0] row_count;
  logic [RW-1:0]             reserved;
  logic                      accept;
  logic                      line_end;
  logic                      frame_end;
  logic                      has_result;
  logic [XW-1:0]             col_clip;
  logic [AW-1:0]             rd_addr;
  logic                      out_pop;

  assign s_axis_tready = (reserved < RW'(FIFO_DEPTH));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_pop       = m_axis_tvalid && m_axis_tready;

  always_comb begin
    line_end   = XW'(column_count) >= (width_sat - XW'(1));
    frame_end  = line_end && (XW'(row_count) >= (height_sat - XW'(1)));
    has_result = (row_count >= dwc_pkg::DIM_W'(2)) && (column_count >= dwc_pkg::DIM_W'(2));
    col_clip   = (XW'(column_count) < XW'(MAX_LINE_WIDTH)) ? XW'(column_count)
                                                           : XW'(MAX_LINE_WIDTH - 1);
    rd_addr    = col_clip[AW-1:0];
  end

  // Column and row counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (line_end) begin
        column_count <= '0;
        row_count    <= frame_end ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // Credit count: results accepted and not yet taken by the receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      reserved <= reserved + RW'(accept && has_result) - RW'(out_pop);
    end
  end

  // Window stage registers, loaded as the line store read is issued.
  logic                      s1_valid;
  dwc_pkg::push_t            s1_info;
  logic [AW-1:0]             s1_addr;
  logic signed [SW-1:0]      s1_in [NUM_CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s1_info.valid <= 1'b0;
    end else begin
      s1_valid      <= accept;
      s1_info.valid <= accept && has_result;
    end
    if (accept) begin
      s1_info.row  <= dwc_pkg::POS_W'(row_count - 1'b1);
      s1_info.col  <= dwc_pkg::POS_W'(column_count - 1'b1);
      s1_info.last <= frame_end;
      s1_addr      <= rd_addr;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        for (int b = 0; b < SW; b++) begin
          s1_in[c][b] <= (b < SB) ? s_axis_tdata[c*SW + b] : s_axis_tdata[c*SW + SB - 1];
        end
      end
    end
  end

  // Line stores: upper holds two rows back, lower one row back.
  logic [LW-1:0] upper_rd;
  logic [LW-1:0] lower_rd;
  logic [LW-1:0] lower_wr;

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      lower_wr[c*SW +: SW] = s1_in[c];
    end
  end

  dwc_ram #(.WIDTH(LW), .DEPTH(MAX_LINE_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (lower_rd),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (upper_rd)
  );

  dwc_ram #(.WIDTH(LW), .DEPTH(MAX_LINE_WIDTH)) u_lower (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (lower_wr),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (lower_rd)
  );

  // Current column of the window and the two columns to its left.
  logic signed [SW-1:0] cur [3][NUM_CHANNELS];
  logic signed [SW-1:0] win [2][3][NUM_CHANNELS];

  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      cur[0][c] = upper_rd[c*SW +: SW];
      cur[1][c] = lower_rd[c*SW +: SW];
      cur[2][c] = s1_in[c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int x = 0; x < 2; x++) begin
        for (int y = 0; y < 3; y++) begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            win[x][y][c] <= '0;
          end
        end
      end
    end else if (s1_valid) begin
      for (int y = 0; y < 3; y++) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          win[0][y][c] <= win[1][y][c];
          win[1][y][c] <= cur[y][c];
        end
      end
    end
  end

  // Channel lanes.
  logic [dwc_pkg::NCH-1:0][dwc_pkg::OUT_W-1:0] lane_res;

  for (genvar ch = 0; ch < dwc_pkg::NCH; ch++) begin : g_lane
    if (ch < NUM_CHANNELS) begin : g_used
      logic signed [SW-1:0]              taps  [dwc_pkg::TAPS];
      logic signed [dwc_pkg::COEF_W-1:0] coefs [dwc_pkg::TAPS];

      for (genvar t = 0; t < dwc_pkg::TAPS; t++) begin : g_tap
        localparam int K = ch * dwc_pkg::TAPS + t;
        assign coefs[t] = coef_pack[K / 4][16 * (K % 4) +: dwc_pkg::COEF_W];
        if ((t % 3) < 2) begin : g_win
          assign taps[t] = win[t % 3][t / 3][ch];
        end else begin : g_cur
          assign taps[t] = cur[t / 3][ch];
        end
      end

      dwc_lane u_lane (
        .clk    (clk),
        .taps   (taps),
        .coefs  (coefs),
        .ident  (identity && (ch == 0)),
        .center (win[1][1][ch]),
        .result (lane_res[ch])
      );
    end else begin : g_unused
      assign lane_res[ch] = '0;
    end
  end

  // Position and flag delay matching the three lane stages.
  dwc_pkg::push_t info_d [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        info_d[i] <= '0;
      end
    end else begin
      info_d[0] <= s1_info;
      for (int i = 1; i < 3; i++) begin
        info_d[i] <= info_d[i-1];
      end
    end
  end

  // Merge and output queue.
  dwc_merge #(.DEPTH(FIFO_DEPTH)) u_merge (
    .clk           (clk),
    .rst           (rst),
    .push          (info_d[2]),
    .lane_res      (lane_res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Checks on the credit scheme and the counters.
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    reserved <= RW'(FIFO_DEPTH))
    else $error("credit count exceeds the output queue depth");

  a_credit_cover: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> reserved != '0)
    else $error("output word present without a matching credit");

  a_line_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && line_end) |=> column_count == '0)
    else $error("column counter did not wrap at the end of a line");

  a_push_credit: assert property (@(posedge clk) disable iff (rst)
    info_d[2].valid |-> reserved != '0)
    else $error("result pushed to the queue without a credit");

endmodule
